/* hdl/mbe_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the log lookup table of the escape-time block.
package mbe_pkg;

	localparam int MAX_ITER = 255;
	localparam int GRID_DIM = 1024;
	localparam int FRAC_BITS = 28;
	localparam int ROM_DEPTH = 256;
	localparam logic [63:0] LOG10_2_Q32 = 64'd1292913986;

	localparam logic signed [31:0] REAL_MIN_RST = -32'sd536870912;
	localparam logic signed [31:0] IMAG_MIN_RST = -32'sd268435456;
	localparam logic [30:0] STEP_RST = 31'd1048576;
	localparam logic [7:0] MAX_ITER_RST = 8'd255;

	localparam logic [7:0] CFG_REAL_MIN = 8'd0;
	localparam logic [7:0] CFG_IMAG_MIN = 8'd1;
	localparam logic [7:0] CFG_STEP = 8'd2;
	localparam logic [7:0] CFG_MAX_ITER = 8'd3;

	localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
	localparam logic signed [63:0] SAT_LO = -64'sd2147483648;
	localparam logic signed [63:0] ESC_LIMIT = 64'sd4 <<< FRAC_BITS;

	typedef struct packed {
		logic load;
		logic init;
		logic mul;
		logic upd;
		logic fin;
	} mbe_cmd_t;

	typedef struct packed {
		logic esc;
		logic last;
	} mbe_sts_t;

	typedef logic [ROM_DEPTH-1:0][15:0] log_rom_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[31:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[31:0];
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic log_rom_t build_log_rom();
		log_rom_t rom;
		logic [63:0] m;
		logic [63:0] frac;
		logic [63:0] l;
		logic [63:0] prod;
		int k;
		int nv;
		int e;
		int i;
		rom = '0;
		for (e = 0; e < ROM_DEPTH; e++) begin
			nv = (e == 0) ? 1 : e;
			k = 0;
			while (k < 31 && (nv >> (k + 1)) != 0) begin
				k++;
			end
			if (k > 30) begin
				k = 30;
			end
			m = (64'(nv) << (30 - k)) & 64'hFFFF_FFFF;
			frac = '0;
			for (i = 1; i <= 32; i++) begin
				m = (m * m) >> 30;
				if (m >= 64'h8000_0000) begin
					m = m >> 1;
					frac = frac | (64'd1 << (32 - i));
				end
			end
			l = ((64'(k) << 32) + frac) >> 8;
			prod = l * LOG10_2_Q32;
			rom[e] = 16'(((prod + (64'd1 << 41)) >> 42) + 64'd16384);
		end
		return rom;
	endfunction

	localparam log_rom_t LOG_ROM = build_log_rom();

endpackage

/* hdl/mbe_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine that sequences point setup and the iteration loop.
module mbe_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  mbe_pkg::mbe_sts_t sts,
	output mbe_pkg::mbe_cmd_t cmd,
	output logic             busy,
	output logic             done
);

	typedef enum logic [1:0] {ST_IDLE, ST_CGEN, ST_MUL, ST_UPD} state_t;

	state_t state_q;
	logic   done_q;
	logic   accept;
	logic   finish;

	assign accept = start && (state_q == ST_IDLE);
	assign finish = (state_q == ST_UPD) && (sts.esc || sts.last);

	always_comb begin
		cmd.load = accept;
		cmd.init = (state_q == ST_CGEN);
		cmd.mul = (state_q == ST_MUL);
		cmd.upd = (state_q == ST_UPD) && !sts.esc;
		cmd.fin = finish;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= finish;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CGEN;
					end
				end
				ST_CGEN: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_MUL;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result strobe while a point is still in progress");
	a_finish_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> done_q)
		else $error("finished point gave no result strobe");
	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_CGEN))
		else $error("accepted point did not enter setup");
`endif

endmodule

/* hdl/mbe_dp.sv */
`timescale 1ns / 1ps
// Datapath: grid coordinate, complex squaring, escape test and result registers.
module mbe_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mbe_pkg::mbe_cmd_t        cmd,
	output mbe_pkg::mbe_sts_t        sts,
	input  logic [9:0]              row,
	input  logic [9:0]              col,
	input  logic signed [31:0]      real_min,
	input  logic signed [31:0]      imag_min,
	input  logic [30:0]             step,
	input  logic [7:0]              max_iter,
	output logic [7:0]              iteration_count,
	output logic [15:0]             log_value
);

	logic [9:0]         row_c;
	logic [9:0]         col_c;
	logic [40:0]        pcx_q;
	logic [40:0]        pcy_q;
	logic signed [31:0] cx_q;
	logic signed [31:0] cy_q;
	logic signed [31:0] zx_q;
	logic signed [31:0] zy_q;
	logic signed [63:0] sxx_q;
	logic signed [63:0] syy_q;
	logic signed [63:0] sxy_q;
	logic [7:0]         n_q;
	logic [7:0]         lim;
	logic [7:0]         cnt_fin;
	logic [7:0]         iteration_count_q;
	logic [15:0]        log_value_q;
	logic signed [63:0] cx_sum;
	logic signed [63:0] cy_sum;
	logic signed [63:0] diff;
	logic signed [63:0] nx_sum;
	logic signed [63:0] ny_sum;
	logic signed [63:0] mag;

	always_comb begin
		row_c = row;
		col_c = col;
		if ({1'b0, row} > 11'(mbe_pkg::GRID_DIM - 1)) begin
			row_c = 10'(mbe_pkg::GRID_DIM - 1);
		end
		if ({1'b0, col} > 11'(mbe_pkg::GRID_DIM - 1)) begin
			col_c = 10'(mbe_pkg::GRID_DIM - 1);
		end
	end

	always_comb begin
		lim = max_iter;
		if ({9'b0, max_iter} > 17'(mbe_pkg::MAX_ITER)) begin
			lim = 8'(mbe_pkg::MAX_ITER);
		end
		if (lim == 8'd0) begin
			lim = 8'd1;
		end
	end

	assign cx_sum = 64'(real_min) + {23'b0, pcx_q};
	assign cy_sum = 64'(imag_min) + {23'b0, pcy_q};
	assign diff = sxx_q - syy_q;
	assign nx_sum = (diff >>> mbe_pkg::FRAC_BITS) + 64'(cx_q);
	assign ny_sum = (sxy_q >>> (mbe_pkg::FRAC_BITS - 1)) + 64'(cy_q);
	assign mag = (sxx_q >>> mbe_pkg::FRAC_BITS) + (syy_q >>> mbe_pkg::FRAC_BITS);

	assign sts.esc = (n_q != 8'd0) && (mag > mbe_pkg::ESC_LIMIT);
	assign sts.last = (({1'b0, n_q} + 9'd1) == {1'b0, lim});
	assign cnt_fin = cmd.upd ? (n_q + 8'd1) : n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= 8'd0;
			iteration_count_q <= 8'd0;
			log_value_q <= 16'd0;
		end else begin
			if (cmd.init) begin
				n_q <= 8'd0;
			end else if (cmd.upd) begin
				n_q <= n_q + 8'd1;
			end
			if (cmd.fin) begin
				iteration_count_q <= cnt_fin;
				log_value_q <= mbe_pkg::LOG_ROM[cnt_fin];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pcx_q <= 41'(step) * 41'(col_c);
			pcy_q <= 41'(step) * 41'(row_c);
		end
		if (cmd.init) begin
			cx_q <= mbe_pkg::sat32(cx_sum);
			cy_q <= mbe_pkg::sat32(cy_sum);
			zx_q <= '0;
			zy_q <= '0;
		end else if (cmd.upd) begin
			zx_q <= mbe_pkg::sat32(nx_sum);
			zy_q <= mbe_pkg::sat32(ny_sum);
		end
		if (cmd.mul) begin
			sxx_q <= zx_q * zx_q;
			syy_q <= zy_q * zy_q;
			sxy_q <= zx_q * zy_q;
		end
	end

	assign iteration_count = iteration_count_q;
	assign log_value = log_value_q;

`ifndef SYNTHESIS
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |=> (n_q == $past(n_q) + 8'd1))
		else $error("iteration count did not advance by one");
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> (iteration_count_q != 8'd0))
		else $error("result word carries a zero iteration count");
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> (iteration_count_q <= $past(lim)))
		else $error("iteration count exceeds the limit");
`endif

endmodule

/* hdl/mandelbrot_escape_time.sv */
`timescale 1ns / 1ps
// Top level of the escape-time block: configuration registers and unit wiring.
//
// Usage: write real_min, imag_min, step and max_iter over the configuration
// channel (index 0 to 3, always ready, unknown indexes are dropped) while the
// block is idle. Issue a point by raising start with row and col; it is taken
// at a clock edge where start is high and busy is low, and busy stays high
// until the result word is out. The result word appears on iteration_count
// and log_value, marked by done, which is high for exactly one cycle; the
// receiver cannot stall it. Acceptance registers the grid offset and the
// setup state forms c and clears z; then each iteration runs on one set of
// three shared multipliers: the multiply state squares z, and the update
// state updates z and tests the previous z for escape. A new point is
// accepted in the cycle done is high. Reset stops any point in progress and
// restores the configuration defaults.
module mandelbrot_escape_time (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [9:0]  row,
	input  logic [9:0]  col,
	output logic        done,
	output logic [7:0]  iteration_count,
	output logic [15:0] log_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic signed [31:0] real_min_q;
	logic signed [31:0] imag_min_q;
	logic [30:0]        step_q;
	logic [7:0]         max_iter_q;
	mbe_pkg::mbe_cmd_t  cmd;
	mbe_pkg::mbe_sts_t  sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			real_min_q <= mbe_pkg::REAL_MIN_RST;
			imag_min_q <= mbe_pkg::IMAG_MIN_RST;
			step_q <= mbe_pkg::STEP_RST;
			max_iter_q <= mbe_pkg::MAX_ITER_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mbe_pkg::CFG_REAL_MIN: begin
					real_min_q <= cfg_data;
				end
				mbe_pkg::CFG_IMAG_MIN: begin
					imag_min_q <= cfg_data;
				end
				mbe_pkg::CFG_STEP: begin
					step_q <= cfg_data[30:0];
				end
				mbe_pkg::CFG_MAX_ITER: begin
					max_iter_q <= cfg_data[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	mbe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mbe_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.row             (row),
		.col             (col),
		.real_min        (real_min_q),
		.imag_min        (imag_min_q),
		.step            (step_q),
		.max_iter        (max_iter_q),
		.iteration_count (iteration_count),
		.log_value       (log_value)
	);

endmodule
